>>> hdl/lcd_four_bit_write_sequencer_macros.svh
// assertion macros shared by the lcd four-bit write sequencer rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef LCD_FOUR_BIT_WRITE_SEQUENCER_MACROS_SVH
`define LCD_FOUR_BIT_WRITE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LCD4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LCD4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lcd4_pkg.sv
// types, codes and microcode rom for the lcd four-bit write sequencer
// no dependencies
package lcd4_pkg;

    // request opcodes
    typedef enum logic [2:0] {
        OP_CMD    = 3'd0,
        OP_DATA   = 3'd1,
        OP_CURSOR = 3'd2,
        OP_INIT   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        RA_ENABLE  = 3'd0,
        RA_NIBBLE  = 3'd1,
        RA_BYTE    = 3'd2,
        RA_POWERUP = 3'd3,
        RA_CLEAR   = 3'd4
    } t_reg;

    // register reset values in microseconds
    localparam logic [15:0] RST_ENABLE_US  = 16'd1;
    localparam logic [15:0] RST_NIBBLE_US  = 16'd100;
    localparam logic [15:0] RST_BYTE_US    = 16'd2000;
    localparam logic [15:0] RST_POWERUP_US = 16'd20000;
    localparam logic [15:0] RST_CLEAR_US   = 16'd3000;

    // cursor address bases for rows one and two
    localparam logic [3:0] CURSOR_ROW1_HI = 4'h8;
    localparam logic [3:0] CURSOR_ROW2_HI = 4'hC;
    localparam logic [1:0] ROW_ONE        = 2'd1;
    localparam logic [1:0] ROW_TWO        = 2'd2;

    // nibble source of a step
    typedef enum logic [1:0] {
        NS_REQ_HI = 2'd0,
        NS_REQ_LO = 2'd1,
        NS_CONST  = 2'd2
    } t_nsrc;

    // hold time source of a step
    typedef enum logic [2:0] {
        HS_EN   = 3'd0,
        HS_NIB  = 3'd1,
        HS_BYTE = 3'd2,
        HS_PWR  = 3'd3,
        HS_CLR  = 3'd4
    } t_hsel;

    // one microcode word = one pin step
    typedef struct packed {
        t_nsrc      nsrc;
        logic [3:0] nib;
        logic       en;
        t_hsel      hsel;
        logic       last;
    } t_uword;

    // configuration register file contents
    typedef struct packed {
        logic [15:0] en_us;
        logic [15:0] nib_us;
        logic [15:0] byte_us;
        logic [15:0] pwr_us;
        logic [15:0] clr_us;
    } t_cfg;

    // program counter and entry points
    localparam int UROM_DEPTH = 34;
    localparam int UA_W       = $clog2(UROM_DEPTH);
    localparam logic [UA_W-1:0] UA_REQ   = UA_W'(0);
    localparam logic [UA_W-1:0] UA_INIT  = UA_W'(4);
    localparam logic [UA_W-1:0] UA_CLEAR = UA_W'(25);
    localparam logic [UA_W-1:0] UA_LAST  = UA_W'(UROM_DEPTH - 1);

    // request handed from the front end to the sequencer
    typedef struct packed {
        logic            start;
        logic [UA_W-1:0] entry;
        logic [7:0]      byte_val;
        logic            rs;
    } t_req;

    // microcode program
    localparam t_uword UROM [UROM_DEPTH] = '{
        // request byte: command, data or cursor address
        '{NS_REQ_HI, 4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_REQ_HI, 4'h0, 1'b0, HS_NIB,  1'b0},
        '{NS_REQ_LO, 4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_REQ_LO, 4'h0, 1'b0, HS_BYTE, 1'b1},
        // init: power-up wait
        '{NS_CONST,  4'h0, 1'b0, HS_PWR,  1'b0},
        // init: return home
        '{NS_CONST,  4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h0, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h2, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h2, 1'b0, HS_BYTE, 1'b0},
        // init: function set, 4-bit two lines
        '{NS_CONST,  4'h2, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h2, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h8, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h8, 1'b0, HS_BYTE, 1'b0},
        // init: display on
        '{NS_CONST,  4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h0, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'hC, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'hC, 1'b0, HS_BYTE, 1'b0},
        // init: clear
        '{NS_CONST,  4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h0, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h1, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h1, 1'b0, HS_BYTE, 1'b0},
        // init: cursor to row one column two
        '{NS_CONST,  4'h8, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h8, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h2, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h2, 1'b0, HS_BYTE, 1'b1},
        // clear: clear command
        '{NS_CONST,  4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h0, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h1, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h1, 1'b0, HS_BYTE, 1'b0},
        // clear: extra wait with pins as left
        '{NS_CONST,  4'h1, 1'b0, HS_CLR,  1'b0},
        // clear: home to row one
        '{NS_CONST,  4'h8, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h8, 1'b0, HS_NIB,  1'b0},
        '{NS_CONST,  4'h0, 1'b1, HS_EN,   1'b0},
        '{NS_CONST,  4'h0, 1'b0, HS_BYTE, 1'b1}
    };

endpackage

>>> hdl/lcd_four_bit_write_sequencer.sv
// top level of the four-bit lcd write sequencer: request decode, registers, sequencer
// depends on lcd4_pkg, lcd4_cfg_regs and lcd4_useq
//
// channel   dir  handshake                  beat
// request   in   i_in_valid / o_in_stall    opcode, value_byte, row, column
// pin step  out  o_out_valid / i_out_stall  data_nibble, reg_select, enable, hold_us, last
// config    in   apb psel/penable/pready    five 16-bit hold times
//
// one pin step leaves the microcode step counter per clock while the output is free.
// o_in_stall is high while a program runs; the next request is taken in the cycle
// after the final step is loaded, even if that step still waits at the output.
// set cursor on rows 0 or 3 and unknown opcodes are taken and give no steps.
// reset is synchronous, active low, and restores the default hold times.
module lcd_four_bit_write_sequencer
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_value_byte,
    input  logic [1:0]  i_row,
    input  logic [7:0]  i_column,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_data_nibble,
    output logic        o_reg_select,
    output logic        o_enable,
    output logic [15:0] o_hold_us,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_req req;
    logic busy;
    logic acc;
    t_op  op;

    assign op         = t_op'(i_opcode);
    assign acc        = i_in_valid && !busy;
    assign o_in_stall = busy;

    // request decode into entry point and byte
    always_comb begin
        req.start    = 1'b0;
        req.entry    = UA_REQ;
        req.byte_val = i_value_byte;
        req.rs       = 1'b0;
        case (op)
            OP_CMD: begin
                req.start = acc;
            end
            OP_DATA: begin
                req.start = acc;
                req.rs    = 1'b1;
            end
            OP_CURSOR: begin
                req.start    = acc && (i_row == ROW_ONE || i_row == ROW_TWO);
                req.byte_val = {(i_row == ROW_ONE) ? CURSOR_ROW1_HI : CURSOR_ROW2_HI,
                                i_column[3:0]};
            end
            OP_INIT: begin
                req.start = acc;
                req.entry = UA_INIT;
            end
            OP_CLEAR: begin
                req.start = acc;
                req.entry = UA_CLEAR;
            end
            default: ;
        endcase
    end

    lcd4_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcd4_useq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_cfg         (cfg),
        .o_busy        (busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_nibble (o_data_nibble),
        .o_reg_select  (o_reg_select),
        .o_enable      (o_enable),
        .o_hold_us     (o_hold_us),
        .o_last        (o_last)
    );

endmodule

>>> hdl/lcd4_cfg_regs.sv
// apb register file holding the lcd timing values
// depends on lcd4_pkg
module lcd4_cfg_regs
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr;
    t_reg idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg'(paddr[4:2]);

    // register writes, out-of-range addresses ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en_us   <= RST_ENABLE_US;
            r_cfg.nib_us  <= RST_NIBBLE_US;
            r_cfg.byte_us <= RST_BYTE_US;
            r_cfg.pwr_us  <= RST_POWERUP_US;
            r_cfg.clr_us  <= RST_CLEAR_US;
        end else if (wr) begin
            case (idx)
                RA_ENABLE:  r_cfg.en_us   <= pwdata[15:0];
                RA_NIBBLE:  r_cfg.nib_us  <= pwdata[15:0];
                RA_BYTE:    r_cfg.byte_us <= pwdata[15:0];
                RA_POWERUP: r_cfg.pwr_us  <= pwdata[15:0];
                RA_CLEAR:   r_cfg.clr_us  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            RA_ENABLE:  prdata = {16'd0, r_cfg.en_us};
            RA_NIBBLE:  prdata = {16'd0, r_cfg.nib_us};
            RA_BYTE:    prdata = {16'd0, r_cfg.byte_us};
            RA_POWERUP: prdata = {16'd0, r_cfg.pwr_us};
            RA_CLEAR:   prdata = {16'd0, r_cfg.clr_us};
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/lcd4_useq.sv
// microcode step counter, pin-step datapath and output register
// depends on lcd4_pkg and lcd_four_bit_write_sequencer_macros.svh
module lcd4_useq
    import lcd4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  t_cfg        i_cfg,
    output logic        o_busy,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_data_nibble,
    output logic        o_reg_select,
    output logic        o_enable,
    output logic [15:0] o_hold_us,
    output logic        o_last
);

    `include "lcd_four_bit_write_sequencer_macros.svh"

    logic            r_busy;
    logic [UA_W-1:0] r_pc;
    logic [7:0]      r_byte;
    logic            r_rs;
    logic            r_out_valid;
    logic [3:0]      r_nib;
    logic            r_rsel;
    logic            r_en;
    logic [15:0]     r_hold;
    logic            r_last;

    t_uword          w;
    logic            load;
    logic [3:0]      step_nib;
    logic [15:0]     step_hold;

    // fetch the current control word
    assign w    = UROM[r_pc];
    assign load = r_busy && (!r_out_valid || !i_out_stall);

    // nibble select
    always_comb begin
        case (w.nsrc)
            NS_REQ_HI: step_nib = r_byte[7:4];
            NS_REQ_LO: step_nib = r_byte[3:0];
            default:   step_nib = w.nib;
        endcase
    end

    // hold time select
    always_comb begin
        case (w.hsel)
            HS_EN:   step_hold = i_cfg.en_us;
            HS_NIB:  step_hold = i_cfg.nib_us;
            HS_BYTE: step_hold = i_cfg.byte_us;
            HS_PWR:  step_hold = i_cfg.pwr_us;
            HS_CLR:  step_hold = i_cfg.clr_us;
            default: step_hold = i_cfg.en_us;
        endcase
    end

    // step counter and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= UA_REQ;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pc   <= i_req.entry;
            end else if (load) begin
                r_busy <= !w.last;
                r_pc   <= r_pc + UA_W'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch and output beat payload
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_byte <= i_req.byte_val;
            r_rs   <= i_req.rs;
        end
        if (load) begin
            r_nib  <= step_nib;
            r_rsel <= r_rs;
            r_en   <= w.en;
            r_hold <= step_hold;
            r_last <= w.last;
        end
    end

    assign o_busy        = r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_data_nibble = r_nib;
    assign o_reg_select  = r_rsel;
    assign o_enable      = r_en;
    assign o_hold_us     = r_hold;
    assign o_last        = r_last;

    // a program only starts from idle
    `LCD4_ASSERT_NOW(a_start_idle, i_req.start, !r_busy, "start while sequencer busy")
    // the step counter stays inside the program
    `LCD4_ASSERT_NOW(a_pc_range, r_busy, r_pc <= UA_LAST, "step counter out of range")
    // start jumps to the entry point
    `LCD4_ASSERT_NEXT(a_entry, i_req.start, r_busy && r_pc == $past(i_req.entry),
        "entry jump missed")
    // issuing a final step ends the program
    `LCD4_ASSERT_NEXT(a_last_ends, load && w.last, !r_busy && r_out_valid && r_last,
        "final step did not end the program")

endmodule
